[src/lpd_pkg.sv]
package lpd_pkg;

  localparam int unsigned FieldBytes = 4;
  localparam logic [31:0] HeaderBytes = 32'(FieldBytes);

  localparam logic [31:0] MaxBodyLengthReset   = 32'(32 << 20);
  localparam logic [31:0] MaxArgumentCountReset = 32'(200 * 1000);

  // register indexes
  localparam logic REG_MAX_BODY_LENGTH    = 1'b0;
  localparam logic REG_MAX_ARGUMENT_COUNT = 1'b1;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BODY_LONG = 3'd1;
  localparam logic [2:0] ERR_ARGS_MANY = 3'd2;
  localparam logic [2:0] ERR_OVERRUN   = 3'd3;
  localparam logic [2:0] ERR_TRAILING  = 3'd4;

  // bit 2 set: an error is latched
  typedef enum logic [2:0] {
    PH_LEN         = 3'd0,
    PH_COUNT       = 3'd1,
    PH_ARGLEN      = 3'd2,
    PH_DATA        = 3'd3,
    PH_ERR_LONG    = 3'd4,
    PH_ERR_ARGS    = 3'd5,
    PH_ERR_OVERRUN = 3'd6,
    PH_ERR_TRAIL   = 3'd7
  } phase_e;

  typedef struct packed {
    logic [2:0]  error_code;
    logic        frame_done;
    logic        arg_done;
    logic [31:0] arg_number;
    logic        data_valid;
    logic [7:0]  data_byte;
  } lpd_result_t;

  localparam int unsigned ResultWidth = $bits(lpd_result_t);

  function automatic logic [2:0] err_of(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_ERR_LONG:    code = ERR_BODY_LONG;
      PH_ERR_ARGS:    code = ERR_ARGS_MANY;
      PH_ERR_OVERRUN: code = ERR_OVERRUN;
      PH_ERR_TRAIL:   code = ERR_TRAILING;
      default:        code = ERR_NONE;
    endcase
    return code;
  endfunction

endpackage

[src/lpd_parser.sv]
module lpd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [31:0]         max_body_i,
  input  logic [31:0]         max_args_i,
  output logic                res_valid_o,
  output lpd_pkg::lpd_result_t res_o
);

  lpd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  fcnt_q, fcnt_d;
  logic [23:0] facc_q, facc_d;
  logic [31:0] body_q, body_d;
  logic [31:0] args_q, args_d;
  logic [31:0] alen_q, alen_d;
  logic [31:0] aidx_q, aidx_d;

  logic        field_done;
  logic [31:0] field_val;
  logic [23:0] facc_upd;
  logic [31:0] body_dec, args_dec, alen_dec, aidx_inc;
  lpd_pkg::phase_e adv_phase;
  logic        latched;
  logic        is_data, arg_end, frame_end, new_err;

  assign field_done = (fcnt_q == 2'd3);
  assign field_val  = {byte_i, facc_q};
  assign body_dec   = body_q - 32'd1;
  assign args_dec   = args_q - 32'd1;
  assign alen_dec   = alen_q - 32'd1;
  assign aidx_inc   = aidx_q + 32'd1;
  assign latched    = phase_q[2];

  always_comb begin
    case (fcnt_q)
      2'd0:    facc_upd = {facc_q[23:8], byte_i};
      2'd1:    facc_upd = {facc_q[23:16], byte_i, facc_q[7:0]};
      2'd2:    facc_upd = {byte_i, facc_q[15:0]};
      default: facc_upd = '0;
    endcase
  end

  // where the frame goes after an argument completes
  always_comb begin
    if (args_dec == 32'd0) begin
      adv_phase = (body_dec != 32'd0) ? lpd_pkg::PH_ERR_TRAIL : lpd_pkg::PH_LEN;
    end else begin
      adv_phase = (body_dec < lpd_pkg::HeaderBytes) ? lpd_pkg::PH_ERR_OVERRUN
                                                     : lpd_pkg::PH_ARGLEN;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    fcnt_d  = fcnt_q;
    facc_d  = facc_q;
    body_d  = body_q;
    args_d  = args_q;
    alen_d  = alen_q;
    aidx_d  = aidx_q;
    if (step_i) begin
      case (phase_q)
        lpd_pkg::PH_LEN: begin
          fcnt_d = fcnt_q + 2'd1;
          facc_d = facc_upd;
          if (field_done) begin
            if (field_val > max_body_i) begin
              phase_d = lpd_pkg::PH_ERR_LONG;
            end else if (field_val < lpd_pkg::HeaderBytes) begin
              phase_d = lpd_pkg::PH_ERR_OVERRUN;
            end else begin
              body_d  = field_val;
              phase_d = lpd_pkg::PH_COUNT;
            end
          end
        end
        lpd_pkg::PH_COUNT: begin
          body_d = body_dec;
          fcnt_d = fcnt_q + 2'd1;
          facc_d = facc_upd;
          if (field_done) begin
            if (field_val > max_args_i) begin
              phase_d = lpd_pkg::PH_ERR_ARGS;
            end else begin
              args_d = field_val;
              aidx_d = '0;
              if (field_val == 32'd0) begin
                phase_d = (body_dec != 32'd0) ? lpd_pkg::PH_ERR_TRAIL : lpd_pkg::PH_LEN;
              end else begin
                phase_d = (body_dec < lpd_pkg::HeaderBytes) ? lpd_pkg::PH_ERR_OVERRUN
                                                             : lpd_pkg::PH_ARGLEN;
              end
            end
          end
        end
        lpd_pkg::PH_ARGLEN: begin
          body_d = body_dec;
          fcnt_d = fcnt_q + 2'd1;
          facc_d = facc_upd;
          if (field_done) begin
            if (field_val > body_dec) begin
              phase_d = lpd_pkg::PH_ERR_OVERRUN;
            end else if (field_val == 32'd0) begin
              aidx_d  = aidx_inc;
              args_d  = args_dec;
              phase_d = adv_phase;
            end else begin
              alen_d  = field_val;
              phase_d = lpd_pkg::PH_DATA;
            end
          end
        end
        lpd_pkg::PH_DATA: begin
          body_d = body_dec;
          alen_d = alen_dec;
          if (alen_dec == 32'd0) begin
            aidx_d  = aidx_inc;
            args_d  = args_dec;
            phase_d = adv_phase;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // result
  always_comb begin
    is_data   = (phase_q == lpd_pkg::PH_DATA);
    arg_end   = (is_data && (alen_dec == 32'd0))
              || ((phase_q == lpd_pkg::PH_ARGLEN) && field_done && (field_val == 32'd0));
    frame_end = !latched && (phase_q != lpd_pkg::PH_LEN) && (phase_d == lpd_pkg::PH_LEN);
    new_err   = !latched && phase_d[2];
    res_o     = '0;
    res_valid_o = 1'b0;
    if (step_i) begin
      if (latched) begin
        res_valid_o      = 1'b1;
        res_o.error_code = lpd_pkg::err_of(phase_q);
      end else begin
        res_valid_o      = is_data || arg_end || frame_end || new_err;
        res_o.data_byte  = is_data ? byte_i : 8'd0;
        res_o.data_valid = is_data;
        res_o.arg_number = (is_data || arg_end) ? aidx_q : 32'd0;
        res_o.arg_done   = arg_end;
        res_o.frame_done = frame_end;
        res_o.error_code = new_err ? lpd_pkg::err_of(phase_d) : lpd_pkg::ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpd_pkg::PH_LEN;
      fcnt_q  <= '0;
      facc_q  <= '0;
      body_q  <= '0;
      args_q  <= '0;
      alen_q  <= '0;
      aidx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      facc_q  <= facc_d;
      body_q  <= body_d;
      args_q  <= args_d;
      alen_q  <= alen_d;
      aidx_q  <= aidx_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q[2] |=> (phase_q == $past(phase_q)))
    else $error("latched error left its phase");

  a_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_done) |-> (res_o.error_code == lpd_pkg::ERR_NONE))
    else $error("frame end reported together with an error");

  a_data_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == lpd_pkg::PH_DATA)) |-> (res_valid_o && res_o.data_valid))
    else $error("argument byte produced no result");
`endif

endmodule

[src/lpd_out_buf.sv]
module lpd_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lpd_pkg::lpd_result_t data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output lpd_pkg::lpd_result_t data_o
);

  lpd_pkg::lpd_result_t ent_q [2];
  logic [1:0] count_q, count_d;
  logic       rd_ptr_q, wr_ptr_q;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = ent_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full result buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i) |=> (valid_o && $stable(data_o)))
    else $error("waiting result changed");
`endif

endmodule

[src/length_prefixed_request_deframer.sv]
// Length-prefixed request deframer.
// Input: one raw stream byte per s_axis transfer (tdata[7:0]). Frames are a
// 4-byte little-endian body length, a 4-byte argument count, then per argument
// a 4-byte length and its bytes.
// Output: one m_axis transfer per argument byte, empty argument, frame end and
// error, shared where they fall on one byte; other header bytes give none.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 max body length, 1 max argument count); write only while idle.
// Timing: a byte is held in the input register, parsed combinationally and
// written into a two-entry result buffer, from which its result is taken. One
// byte per cycle is sustained while the result buffer is not full; the parse
// step between the input register and the result buffer is combinational.
// Stalls: when the receiver holds m_axis_tready low the buffer fills; from then
// on s_axis_tready is low whenever a byte waits in the input register.
// Nothing is lost.
// Reset: returns to waiting for a frame length, clears any latched error,
// empties both stages and restores the register defaults. Errors stay
// latched until reset; every later byte then returns only the error code.
module length_prefixed_request_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [39:8] arg_number, [40] arg_done
  output logic [3:0]  m_axis_tuser,   // [0] data_valid, [3:1] error_code
  output logic        m_axis_tlast,   // frame_done
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [31:0] max_body_q, max_args_q;
  logic        out_full, fire, res_valid;
  lpd_pkg::lpd_result_t res, out_res;

  assign fire          = in_valid_q && !out_full;
  assign s_axis_tready = !in_valid_q || !out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= lpd_pkg::MaxBodyLengthReset;
      max_args_q <= lpd_pkg::MaxArgumentCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lpd_pkg::REG_MAX_BODY_LENGTH:    max_body_q <= cfg_data_i;
        lpd_pkg::REG_MAX_ARGUMENT_COUNT: max_args_q <= cfg_data_i;
        default:                         max_body_q <= max_body_q;
      endcase
    end
  end

  lpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .byte_i      (in_byte_q),
    .max_body_i  (max_body_q),
    .max_args_i  (max_args_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire && res_valid),
    .data_i  (res),
    .pop_i   (m_axis_tready),
    .full_o  (out_full),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.arg_done, out_res.arg_number, out_res.data_byte};
  assign m_axis_tuser = {out_res.error_code, out_res.data_valid};
  assign m_axis_tlast = out_res.frame_done;

`ifndef NO_ASSERTIONS
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_full) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input byte lost");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input refused with an empty input stage");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !cfg_we_i)
    else $error("configuration written while a byte is parsed");
`endif

endmodule
